[hw/rtl/tga_rle_pixel_decoder_defines.svh]
// Assertion helpers for the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, off during reset
`define TGA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tga_rle_pkg.sv]
`default_nettype none

package tga_rle_pkg;

    // Longest packet: 7-bit count field plus one
    localparam int MAX_RUN = 128;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    // Job queue depth between parser and expander (power of two)
    localparam int JOB_DEPTH_DEF = 2;

    // Config register indexes
    localparam logic [1:0] CFG_COMPRESSED   = 2'd0;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd1;
    localparam logic [1:0] CFG_TOTAL_PIXELS = 2'd2;

    localparam logic [7:0] COUNT_MASK = 8'h7f;
    localparam logic [7:0] RUN_FLAG   = 8'h80;

    typedef enum logic {
        PS_HEADER,
        PS_PIXELS
    } parse_state_t;

    typedef struct packed {
        logic        compressed;
        logic        pixel_format;
        logic [31:0] total_pixels;
    } cfg_t;

    // One decoded pixel and how many times it is repeated
    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [CNT_W-1:0] count;
        logic             ends_image;
    } job_t;

    typedef struct packed {
        logic [7:0] red0;
        logic [7:0] green0;
        logic [7:0] blue0;
        logic [7:0] alpha0;
        logic [7:0] red1;
        logic [7:0] green1;
        logic [7:0] blue1;
        logic [7:0] alpha1;
        logic [1:0] pixels_here;
        logic       last_of_run;
        logic       end_of_image;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/tga_rle_front.sv]
`default_nettype none

module tga_rle_front
    import tga_rle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       push,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_start,
    input  wire logic       job_full,
    output logic            job_push,
    output job_t            job
);

    parse_state_t     state_reg, state_next;
    logic             run_packet_reg, run_packet_next;
    logic [CNT_W-1:0] packet_left_reg, packet_left_next;
    logic [1:0]       byte_slot_reg, byte_slot_next;
    logic [31:0]      pixels_done_reg, pixels_done_next;
    logic [7:0]       pix_reg [4];
    logic [7:0]       pix_new [4];

    logic             accept;
    parse_state_t     eff_state;
    logic [CNT_W-1:0] eff_left;
    logic [1:0]       eff_slot;
    logic [31:0]      eff_done;
    logic [32:0]      remain;
    logic             image_done;
    logic             is_header;
    logic [2:0]       slot_inc;
    logic [2:0]       bpp;
    logic             completes;
    logic [CNT_W-1:0] n_raw;
    logic [CNT_W-1:0] left_dec;
    logic             ends;
    logic             fire;

    assign accept = push && !job_full;

    // Frame start clears the packet state before the byte is used
    always_comb
    begin
        eff_state = frame_start ? PS_HEADER : state_reg;
        eff_left  = frame_start ? '0 : packet_left_reg;
        eff_slot  = frame_start ? 2'd0 : byte_slot_reg;
        eff_done  = frame_start ? 32'd0 : pixels_done_reg;
    end

    // Pixels still owed, and pixel assembly
    always_comb
    begin
        remain     = {1'b0, cfg.total_pixels} - {1'b0, eff_done};
        image_done = remain[32] || (remain[31:0] == 32'd0);
        is_header  = cfg.compressed && (eff_state == PS_HEADER);
        for (int i = 0; i < 4; i++)
        begin
            pix_new[i] = (eff_slot == 2'(i)) ? data_byte : pix_reg[i];
        end
        slot_inc  = {1'b0, eff_slot} + 3'd1;
        bpp       = cfg.pixel_format ? 3'd4 : 3'd3;
        completes = (slot_inc >= bpp);
        left_dec  = (eff_left == '0) ? '0 : eff_left - CNT_W'(1);
        if (cfg.compressed && run_packet_reg)
            n_raw = (eff_left == '0) ? CNT_W'(1) : eff_left;
        else
            n_raw = CNT_W'(1);
        // Clip to the image total; the clipped job is the image's last
        ends = (remain[31:CNT_W] == '0) && (remain[CNT_W-1:0] <= n_raw);
        fire = accept && !image_done && !is_header && completes;
    end

    // Next parse state
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = eff_state;
            if (!image_done)
            begin
                if (is_header)
                    state_next = PS_PIXELS;
                else if (completes && cfg.compressed)
                begin
                    if (run_packet_reg || (left_dec == '0))
                        state_next = PS_HEADER;
                end
            end
        end
    end

    // Datapath state and job output
    always_comb
    begin
        run_packet_next  = run_packet_reg;
        packet_left_next = packet_left_reg;
        byte_slot_next   = byte_slot_reg;
        pixels_done_next = pixels_done_reg;
        if (accept)
        begin
            packet_left_next = eff_left;
            byte_slot_next   = eff_slot;
            pixels_done_next = eff_done;
            if (!image_done)
            begin
                if (is_header)
                begin
                    run_packet_next  = (data_byte & RUN_FLAG) != 8'd0;
                    packet_left_next = CNT_W'(data_byte & COUNT_MASK) + CNT_W'(1);
                    byte_slot_next   = 2'd0;
                end
                else if (!completes)
                begin
                    byte_slot_next = slot_inc[1:0];
                end
                else
                begin
                    byte_slot_next = 2'd0;
                    if (cfg.compressed)
                        packet_left_next = run_packet_reg ? '0 : left_dec;
                    pixels_done_next = ends ? cfg.total_pixels
                                            : eff_done + 32'(n_raw);
                end
            end
        end

        job_push        = fire;
        job.red         = pix_new[2];
        job.green       = pix_new[1];
        job.blue        = pix_new[0];
        job.alpha       = cfg.pixel_format ? pix_new[3] : 8'd0;
        job.count       = ends ? remain[CNT_W-1:0] : n_raw;
        job.ends_image  = ends;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= PS_HEADER;
            run_packet_reg  <= 1'b0;
            packet_left_reg <= '0;
            byte_slot_reg   <= 2'd0;
            pixels_done_reg <= 32'd0;
        end
        else
        begin
            state_reg       <= state_next;
            run_packet_reg  <= run_packet_next;
            packet_left_reg <= packet_left_next;
            byte_slot_reg   <= byte_slot_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

    // Pixel byte store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && !image_done && !is_header)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pix_reg[i] <= pix_new[i];
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tga_rle_job_fifo.sv]
`default_nettype none

module tga_rle_job_fifo
    import tga_rle_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      valid
);

    localparam int PTR_W = $clog2(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (!do_wr && do_rd)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

[hw/rtl/tga_rle_back.sv]
`default_nettype none

module tga_rle_back
    import tga_rle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_pop,
    input  wire logic pop,
    output logic      empty,
    output result_t   res
);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             load;
    logic [CNT_W-1:0] rem;
    logic             two;
    logic [CNT_W-1:0] rem_after;

    assign empty = !out_valid_reg;
    assign res   = res_reg;

    // Expand the head job up to two pixels per transfer
    always_comb
    begin
        load      = job_valid && (!out_valid_reg || pop);
        rem       = active_reg ? rem_reg : job.count;
        two       = (rem >= CNT_W'(2));
        rem_after = rem - (two ? CNT_W'(2) : CNT_W'(1));

        active_next    = active_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !pop;
        res_next       = res_reg;
        job_pop        = 1'b0;
        if (load)
        begin
            out_valid_next        = 1'b1;
            res_next.red0         = job.red;
            res_next.green0       = job.green;
            res_next.blue0        = job.blue;
            res_next.alpha0       = job.alpha;
            res_next.red1         = two ? job.red : 8'd0;
            res_next.green1       = two ? job.green : 8'd0;
            res_next.blue1        = two ? job.blue : 8'd0;
            res_next.alpha1       = two ? job.alpha : 8'd0;
            res_next.pixels_here  = two ? 2'd2 : 2'd1;
            res_next.last_of_run  = (rem_after == '0);
            res_next.end_of_image = (rem_after == '0) && job.ends_image;
            rem_next              = rem_after;
            active_next           = (rem_after != '0);
            job_pop               = (rem_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

[hw/rtl/tga_rle_pixel_decoder.sv]
// A pixel's last byte is registered in the job queue, then in the expander's output register.
// Input: one byte per cycle while the parser-to-expander job queue has room (full = queue full).
// Output: one result per cycle while a job waits and pop is high; ceil(n/2) results per run of n.
// The expander's output register lets new bytes enter while a result waits for pop.
// Reset: packet state, pixel count and queues clear; compressed=1, pixel_format=0, total_pixels=1.
`default_nettype none

module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       red0,
    output logic [7:0]       green0,
    output logic [7:0]       blue0,
    output logic [7:0]       alpha0,
    output logic [7:0]       red1,
    output logic [7:0]       green1,
    output logic [7:0]       blue1,
    output logic [7:0]       alpha1,
    output logic [1:0]       pixels_here,
    output logic             last_of_run,
    output logic             end_of_image
);

    cfg_t    cfg_reg, cfg_next;
    logic    job_push;
    job_t    job_in;
    logic    job_full;
    logic    job_pop;
    job_t    job_head;
    logic    job_valid;
    result_t res;

    // Config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COMPRESSED:   cfg_next.compressed   = cfg_data[0];
                CFG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[0];
                CFG_TOTAL_PIXELS: cfg_next.total_pixels = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressed   <= 1'b1;
            cfg_reg.pixel_format <= 1'b0;
            cfg_reg.total_pixels <= 32'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = job_full;

    tga_rle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .job_full    (job_full),
        .job_push    (job_push),
        .job         (job_in)
    );

    tga_rle_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .valid   (job_valid)
    );

    tga_rle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // Result fields to ports
    assign red0         = res.red0;
    assign green0       = res.green0;
    assign blue0        = res.blue0;
    assign alpha0       = res.alpha0;
    assign red1         = res.red1;
    assign green1       = res.green1;
    assign blue1        = res.blue1;
    assign alpha1       = res.alpha1;
    assign pixels_here  = res.pixels_here;
    assign last_of_run  = res.last_of_run;
    assign end_of_image = res.end_of_image;

endmodule

`default_nettype wire

[hw/rtl/tga_rle_checker.sv]
`default_nettype none

`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] red0,
    input wire logic [7:0] red1,
    input wire logic [7:0] green1,
    input wire logic [7:0] blue1,
    input wire logic [7:0] alpha1,
    input wire logic [1:0] pixels_here,
    input wire logic       last_of_run,
    input wire logic       end_of_image
);

    // A waiting result holds until its transfer
    `TGA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(red0) && $stable(pixels_here), "result changed while stalled")

    // Each result carries one or two pixels
    `TGA_ASSERT_NOW(a_here_range, !empty, (pixels_here == 2'd1) || (pixels_here == 2'd2), "bad pixel count")

    // The image's last pixel closes its run's results
    `TGA_ASSERT_NOW(a_end_last, !empty && end_of_image, last_of_run, "end of image without last of run")

    // An unused second pixel reads as zero
    `TGA_ASSERT_NOW(a_second_zero, !empty && (pixels_here == 2'd1), (red1 == 8'd0) && (green1 == 8'd0) && (blue1 == 8'd0) && (alpha1 == 8'd0), "second pixel not cleared")

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .red0         (red0),
    .red1         (red1),
    .green1       (green1),
    .blue1        (blue1),
    .alpha1       (alpha1),
    .pixels_here  (pixels_here),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
);

`default_nettype wire

[dv/tga_rle_pixel_decoder_tb.sv]
`default_nettype none

module tga_rle_pixel_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tga_rle_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 10;
    localparam int          ITEM_TARGET   = 470;
    localparam int          TAIL_ITEMS    = 60;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PRINT_LIMIT   = 100;
    localparam logic [31:0] TOTAL_MAX     = 32'd4294836225;
    // index past the last register, writes there must be ignored
    localparam logic [1:0]  CFG_SPARE     = 2'd3;

    typedef logic [7:0] byte_stream_t [$];

    // Decoder state mirror and store of expected pixel results
    class pixel_scoreboard;
        cfg_t        cfg;
        bit          hdr_wanted;
        bit          in_run;
        bit [7:0]    pkt_remaining;
        bit [1:0]    slot;
        bit [7:0]    pix_buf [4];
        bit [31:0]   pix_count;
        result_t     expected_pixels [$];
        int          errors;
        int          checked;

        function new();
            cfg.compressed   = 1'b1;
            cfg.pixel_format = 1'b0;
            cfg.total_pixels = 32'd1;
            hdr_wanted       = 1'b1;
            in_run           = 1'b0;
            pkt_remaining    = '0;
            slot             = '0;
            pix_count        = '0;
            foreach (pix_buf[i])
                pix_buf[i] = '0;
            errors           = 0;
            checked          = 0;
        endfunction

        function void write_cfg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_COMPRESSED:   cfg.compressed   = val[0];
                CFG_PIXEL_FORMAT: cfg.pixel_format = val[0];
                CFG_TOTAL_PIXELS: cfg.total_pixels = val;
                default: ;
            endcase
        endfunction

        // Queue n copies of the buffered pixel, up to two per result
        function void emit_copies(bit [31:0] n);
            result_t r;
            int      made;
            made = 0;
            while (n != 0 && made < MAX_RUN / 2) begin
                r        = '0;
                r.red0   = pix_buf[2];
                r.green0 = pix_buf[1];
                r.blue0  = pix_buf[0];
                r.alpha0 = cfg.pixel_format ? pix_buf[3] : 8'h00;
                if (n >= 2) begin
                    r.red1        = pix_buf[2];
                    r.green1      = pix_buf[1];
                    r.blue1       = pix_buf[0];
                    r.alpha1      = cfg.pixel_format ? pix_buf[3] : 8'h00;
                    r.pixels_here = 2'd2;
                    n             = n - 2;
                    pix_count     = pix_count + 2;
                end
                else begin
                    r.pixels_here = 2'd1;
                    n             = n - 1;
                    pix_count     = pix_count + 1;
                end
                r.last_of_run  = (n == 0);
                r.end_of_image = (pix_count >= cfg.total_pixels);
                expected_pixels.push_back(r);
                made++;
            end
        endfunction

        // Note one transferred byte; returns 0 when the decoder drops it
        function bit decode_byte(logic [7:0] b, logic fs);
            bit [2:0]  bpp;
            bit [2:0]  next_slot;
            bit [31:0] room;
            bit [31:0] n;
            bpp = cfg.pixel_format ? 3'd4 : 3'd3;
            if (fs) begin
                hdr_wanted    = 1'b1;
                pkt_remaining = '0;
                slot          = '0;
                pix_count     = '0;
            end
            if (pix_count >= cfg.total_pixels)
                return 1'b0;
            room = cfg.total_pixels - pix_count;

            // packet header
            if (cfg.compressed && hdr_wanted) begin
                in_run        = ((b & RUN_FLAG) != 0);
                pkt_remaining = (b & COUNT_MASK) + 8'd1;
                hdr_wanted    = 1'b0;
                slot          = '0;
                return 1'b1;
            end

            // collect pixel bytes
            pix_buf[slot] = b;
            next_slot     = {1'b0, slot} + 3'd1;
            if (next_slot < bpp) begin
                slot = next_slot[1:0];
                return 1'b1;
            end
            slot = '0;

            if (!cfg.compressed) begin
                n = 1;
            end
            else if (in_run) begin
                n = (pkt_remaining == 0) ? 32'd1 : 32'(pkt_remaining);
                if (n > room)
                    n = room;
                pkt_remaining = '0;
                hdr_wanted    = 1'b1;
            end
            else begin
                if (pkt_remaining > 0)
                    pkt_remaining--;
                if (pkt_remaining == 0)
                    hdr_wanted = 1'b1;
                n = 1;
            end
            emit_copies(n);
            return 1'b1;
        endfunction

        task report(string line);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, line);
        endtask

        task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("result %0d %s: got %h, expected %h",
                                 checked, name, got_v, want_v));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red0", got.red0, want.red0);
            compare_field("green0", got.green0, want.green0);
            compare_field("blue0", got.blue0, want.blue0);
            compare_field("alpha0", got.alpha0, want.alpha0);
            compare_field("red1", got.red1, want.red1);
            compare_field("green1", got.green1, want.green1);
            compare_field("blue1", got.blue1, want.blue1);
            compare_field("alpha1", got.alpha1, want.alpha1);
            compare_field("pixels_here", 8'(got.pixels_here), 8'(want.pixels_here));
            compare_field("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
            compare_field("end_of_image", 8'(got.end_of_image), 8'(want.end_of_image));
            checked++;
        endtask
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_write   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [31:0] cfg_data    = '0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  data_byte   = '0;
    logic        frame_start = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [7:0]  red0;
    logic [7:0]  green0;
    logic [7:0]  blue0;
    logic [7:0]  alpha0;
    logic [7:0]  red1;
    logic [7:0]  green1;
    logic [7:0]  blue1;
    logic [7:0]  alpha1;
    logic [1:0]  pixels_here;
    logic        last_of_run;
    logic        end_of_image;

    pixel_scoreboard sb = new();

    int  bytes_used   = 0;
    int  push_gap_pct = 20;
    int  pop_gap_pct  = 20;
    bit  quiet_tail   = 1'b0;
    bit  hold_results = 1'b0;
    int  cycle_count  = 0;

    tga_rle_pixel_decoder dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // One byte transfer, with an optional idle burst in front
    task automatic send_byte(input logic [7:0] b, input logic fs);
        if (bytes_used >= ITEM_TARGET)
            return;
        if (bytes_used >= ITEM_TARGET - TAIL_ITEMS)
            quiet_tail = 1'b1;
        if (!quiet_tail && push_gap_pct != 0 && $urandom_range(1, 100) <= push_gap_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        frame_start <= fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        void'(sb.decode_byte(b, fs));
        bytes_used++;
    endtask

    // First byte of the stream carries frame_start
    task automatic send_stream(input byte_stream_t stream);
        foreach (stream[i])
            send_byte(stream[i], i == 0);
    endtask

    // Let every expected result drain, then give the parser time to settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_cfg(idx, val);
    endtask

    // Upper bits of the one-bit registers carry noise
    task automatic apply_config(input bit comp, input bit fmt, input logic [31:0] total);
        logic [31:0] val;
        wait_idle();
        write_reg(CFG_SPARE, $urandom);
        val    = $urandom;
        val[0] = comp;
        write_reg(CFG_COMPRESSED, val);
        val    = $urandom;
        val[0] = fmt;
        write_reg(CFG_PIXEL_FORMAT, val);
        write_reg(CFG_TOTAL_PIXELS, total);
        cfg_write <= 1'b0;
    endtask

    // Well-formed image of about px_target pixels, optionally cut short
    task automatic send_image(input bit comp, input int bpp, input int px_target,
                              input bit broken);
        byte_stream_t stream;
        int           px;
        int           cnt;
        int           cut;
        px = 0;
        while (px < px_target) begin
            if (!comp) begin
                cnt = 1;
                repeat (bpp) stream.push_back(8'($urandom));
            end
            else if ($urandom_range(0, 1) == 1) begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_RUN)
                                                  : $urandom_range(1, 6);
                stream.push_back(RUN_FLAG | 8'(cnt - 1));
                repeat (bpp) stream.push_back(8'($urandom));
            end
            else begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                stream.push_back(8'(cnt - 1));
                repeat (cnt * bpp) stream.push_back(8'($urandom));
            end
            px += cnt;
        end
        if (broken) begin
            cut = $urandom_range(1, stream.size());
            while (stream.size() > cut)
                void'(stream.pop_back());
        end
        send_stream(stream);
    endtask

    // Result side: random pop gaps, one long hold-off on request
    initial begin
        result_t got;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet_tail && pop_gap_pct != 0 &&
                     $urandom_range(1, 100) <= pop_gap_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                @(posedge clk);
                if (!empty) begin
                    got = {red0, green0, blue0, alpha0, red1, green1, blue1, alpha1,
                           pixels_here, last_of_run, end_of_image};
                    sb.check_result(got);
                end
            end
        end
    end

    // Long hold-off: results back up until the decoder stops taking bytes
    initial begin
        int held;
        wait (hold_results);
        held = 0;
        while (held < HOLD_CYCLES) begin
            @(posedge clk);
            held++;
        end
        hold_results = 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** tga_rle_pixel_decoder: FAILED **");
        $finish;
    end

    // Stimulus
    initial begin
        byte_stream_t bq;
        bit           comp;
        bit           fmt;
        logic [31:0]  total;
        int           phase;
        int           px_target;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one three-byte pixel, then a dropped byte
        bq = '{8'h00, 8'h00, 8'hFF, 8'h5A, 8'h80};
        send_stream(bq);

        // longest run with four-byte pixels, then a run of one
        apply_config(1'b1, 1'b1, 32'd200);
        bq = '{8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04};
        send_stream(bq);

        // run of six clipped at the image total
        apply_config(1'b1, 1'b1, 32'd3);
        bq = '{8'h85, 8'hC3, 8'h3C, 8'h0F, 8'hF0};
        send_stream(bq);

        // zero total: nothing is decoded
        apply_config(1'b1, 1'b0, 32'd0);
        bq = '{8'h00, 8'h12};
        send_stream(bq);

        // random images over random settings
        phase = 0;
        while (bytes_used < ITEM_TARGET) begin
            comp = ($urandom_range(0, 4) != 0);
            fmt  = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0:       total = 32'd1;
                1:       total = TOTAL_MAX;
                2:       total = $urandom_range(60, 200);
                default: total = $urandom_range(2, 40);
            endcase
            if (phase == 0) begin
                comp  = 1'b1;
                fmt   = 1'b0;
                total = TOTAL_MAX;
            end
            case ($urandom_range(0, 2))
                0:       push_gap_pct = 0;
                1:       push_gap_pct = 15;
                default: push_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       pop_gap_pct = 0;
                1:       pop_gap_pct = 15;
                default: pop_gap_pct = 40;
            endcase
            apply_config(comp, fmt, total);
            if (phase == 0)
                hold_results = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 11) == 0) begin
                    // noise: random bytes, occasional frame_start
                    repeat ($urandom_range(3, 20))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
                else begin
                    px_target = (total > 32'd200) ? $urandom_range(8, 60)
                                                  : int'(total) + $urandom_range(0, 2);
                    send_image(comp, fmt ? 4 : 3, px_target, $urandom_range(0, 9) == 0);
                end
            end
            phase++;
        end

        // drain and finish
        wait_idle();
        if (sb.expected_pixels.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_pixels.size()));
        if (sb.errors == 0)
            $display("** tga_rle_pixel_decoder: PASSED **");
        else
            $display("** tga_rle_pixel_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
